// ===== rtl/xcfr_pkg.sv =====
package xcfr_pkg;

    localparam int MAX_FRAME = 32;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int ADDR_W    = $clog2(MAX_FRAME);
    localparam int DATA_W    = 8;
    localparam int IDX_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam int MIN_FRAME = 5;
    localparam int LEN_EXTRA = 3;
    localparam int MIN_LEN   = 2;
    localparam int PLD_BASE  = 3;

    localparam logic [DATA_W-1:0] HEAD_RST = 8'hAA;
    localparam logic [DATA_W-1:0] TAIL_RST = 8'h55;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_VERIFY   = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] rx_byte;
        logic              frame_end;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] command;
        logic [DATA_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              has_payload;
        logic              run_last;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic take;
        logic rel;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic pld_start;
        logic pld_last;
    } t_sts;

endpackage

// ===== rtl/xcfr_ram.sv =====
module xcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/xcfr_ctrl.sv =====
module xcfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  xcfr_pkg::t_sts i_sts,
    output xcfr_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import xcfr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_REL  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_sts.pld_start) begin
                    n_state = S_REL;
                end
            end
            S_REL: begin
                if (i_sts.pld_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.take = i_start && (r_state == S_IDLE);
    assign o_cmd.rel  = (r_state == S_REL);
    assign o_busy     = (r_state != S_IDLE);

endmodule

// ===== rtl/xcfr_dp.sv =====
module xcfr_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  xcfr_pkg::t_cmd                      i_cmd,
    input  xcfr_pkg::t_in                       i_item,
    input  logic                                i_cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [xcfr_pkg::DATA_W-1:0]         i_cfg_data,
    output xcfr_pkg::t_sts                      o_sts,
    output logic                                o_valid,
    output xcfr_pkg::t_out                      o_result
);
    import xcfr_pkg::*;

    logic [DATA_W-1:0] r_head;
    logic [DATA_W-1:0] r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_check;
    logic              r_ovf;
    logic [DATA_W-1:0] r_byte0;
    logic [DATA_W-1:0] r_len;
    logic [DATA_W-1:0] r_cmd;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_last_idx;
    logic              r_valid;
    t_out              r_out;

    logic              full;
    logic              ovf_now;
    logic [CNT_W:0]    flen;
    logic [DATA_W:0]   len_plus;
    logic              too_short;
    logic              verify_bad;
    logic              pld_start;
    logic              pld_last;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    t_out              n_out;

    assign full     = (r_count == CNT_W'(MAX_FRAME));
    assign ovf_now  = r_ovf || full;
    assign flen     = {1'b0, r_count} + (CNT_W+1)'(1);
    assign len_plus = {1'b0, r_len} + (DATA_W+1)'(LEN_EXTRA);

    assign too_short  = !ovf_now && (flen < (CNT_W+1)'(MIN_FRAME));
    // The running XOR covers length through checksum, so a good frame leaves zero.
    assign verify_bad = (r_byte0 != r_head) || (i_item.rx_byte != r_tail) ||
                        (r_len < DATA_W'(MIN_LEN)) ||
                        (len_plus != (DATA_W+1)'(flen)) || (r_check != '0);
    assign pld_start  = i_item.frame_end && !too_short && !ovf_now && !verify_bad &&
                        (r_len != DATA_W'(MIN_LEN));
    assign pld_last   = (r_idx == r_last_idx);

    assign o_sts.pld_start = pld_start;
    assign o_sts.pld_last  = pld_last;

    // While idle the store is read at the first payload slot so that its data
    // is ready in the first release cycle.
    assign rd_addr = i_cmd.rel ? ADDR_W'(r_idx + ADDR_W'(PLD_BASE + 1))
                               : ADDR_W'(PLD_BASE);

    xcfr_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_FRAME)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && !full),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_item.rx_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_out = '0;
        n_out.run_last = 1'b1;
        if (i_cmd.rel) begin
            n_out.status        = ST_OK;
            n_out.command       = r_cmd;
            n_out.payload_byte  = rd_data;
            n_out.payload_index = IDX_W'(r_idx);
            n_out.has_payload   = 1'b1;
            n_out.run_last      = pld_last;
        end else if (too_short) begin
            n_out.status = ST_SHORT;
        end else if (ovf_now) begin
            n_out.status = ST_TOO_LONG;
        end else if (verify_bad) begin
            n_out.status = ST_VERIFY;
        end else begin
            n_out.status  = ST_OK;
            n_out.command = r_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= HEAD_RST;
            r_tail  <= TAIL_RST;
            r_count <= '0;
            r_check <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEAD: r_head <= i_cfg_data;
                    CFG_TAIL: r_tail <= i_cfg_data;
                    default: ;
                endcase
            end
            r_valid <= 1'b0;
            if (i_cmd.take) begin
                r_idx <= '0;
                if (i_item.frame_end) begin
                    r_count <= '0;
                    r_check <= '0;
                    r_ovf   <= 1'b0;
                    r_valid <= !pld_start;
                end else begin
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_ovf <= ovf_now;
                    if ((r_count != '0) || ovf_now) begin
                        r_check <= r_check ^ i_item.rx_byte;
                    end
                end
            end else if (i_cmd.rel) begin
                r_idx   <= r_idx + ADDR_W'(1);
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take || i_cmd.rel) begin
            r_out <= n_out;
        end
        if (i_cmd.take && i_item.frame_end) begin
            r_last_idx <= ADDR_W'(r_len - DATA_W'(LEN_EXTRA));
        end
        if (i_cmd.take && !full) begin
            if (r_count == CNT_W'(0)) begin
                r_byte0 <= i_item.rx_byte;
            end
            if (r_count == CNT_W'(1)) begin
                r_len <= i_item.rx_byte;
            end
            if (r_count == CNT_W'(2)) begin
                r_cmd <= i_item.rx_byte;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_out.status != ST_OK) |-> r_out.run_last && !r_out.has_payload)
        else $error("error verdict is not a single final beat");

    a_rel_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rel |=> r_valid && r_out.has_payload)
        else $error("release cycle did not produce a payload beat");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take && i_item.frame_end |=> (r_count == '0) && (r_check == '0) && !r_ovf)
        else $error("frame state not cleared after frame end");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.take && !i_cmd.rel |=> !r_valid)
        else $error("result beat without an input byte or release step");

endmodule

// ===== rtl/xor_checked_frame_receiver_core.sv =====
// Frame receiver with head/tail and XOR checksum verification.
// Input: one byte per beat on i_item (rx_byte, frame_end), taken on a rising
// edge with start high and busy low. frame_end marks the last byte of a frame.
// Configuration: i_cfg_we writes i_cfg_data to head byte (index 0) or tail
// byte (index 1); write only while no frame is in progress.
// Output: o_result is shown for one cycle with o_valid high; the receiver has
// no way to stall it. An error frame, or a valid frame with no payload, gives
// one beat, registered from the last byte. A valid frame with N payload bytes
// gives N beats, one per cycle, the first registered from the first release step.
// Throughput: one byte per cycle while a frame streams in. After a valid frame
// with N payload bytes, busy is high while the payload is read back from the
// frame store, one entry per cycle through its single read port.
// Reset (synchronous, i_rst_n low) sets head to 0xAA and tail to 0x55 and
// empties the byte count and checksum; the frame store is not cleared.
module xor_checked_frame_receiver_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  xcfr_pkg::t_in                      i_item,
    output logic                               o_valid,
    output xcfr_pkg::t_out                     o_result,
    input  logic                               i_cfg_we,
    input  logic [xcfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [xcfr_pkg::DATA_W-1:0]        i_cfg_data
);
    import xcfr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    xcfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    xcfr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule
